### rtl/ese_pkg.sv
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed estimator
// Word formats, configuration register codes, sequencer states and the
// widths of the shared serial divider.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int TS_W    = 32;
  localparam int POS_W   = 32;
  localparam int SPEED_W = 32;
  localparam int ACC_W   = 32;
  localparam int CPT_W   = 9;
  localparam int GAIN_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Serial divider sizing: the divisor 2^F + gain*dt stays below 2^57 and
  // every dividend fits in 58 bits for fraction widths up to 24.
  localparam int DEN_W = GAIN_W + TS_W + 1;
  localparam int DIV_W = DEN_W + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam int STEP_W = CPT_W;
  localparam int GS_W   = GAIN_W + STEP_W;
  localparam int NUM_W  = GS_W + 1;
  localparam int GD_W   = GAIN_W + TS_W;
  localparam int DIFF_W = SPEED_W + 1;

  localparam logic [STEP_W-1:0] FULL_TURN = STEP_W'(360);
  localparam logic [CPT_W-1:0]  RESET_COUNTS_PER_TURN = CPT_W'(20);
  localparam logic [GAIN_W-1:0] RESET_FILTER_GAIN = GAIN_W'(1311);

  localparam logic [CNT_W-1:0] STEP_ITER  = CNT_W'(STEP_W);
  localparam logic [CNT_W-1:0] SPEED_ITER = CNT_W'(NUM_W + FRACTION_BITS);
  localparam logic [CNT_W-1:0] ACC_ITER   = CNT_W'(DIV_W);

  localparam logic [ACC_W-1:0] ACC_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_NEG_MAX = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_TURN = 2'd0,
    CFG_FILTER_GAIN     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [TS_W-1:0] timestamp;
    logic            direction_up;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [SPEED_W-1:0]      speed;
    logic signed [ACC_W-1:0] acceleration;
  } out_word_t;

  typedef struct packed {
    logic [CPT_W-1:0]  counts_per_turn;
    logic [GAIN_W-1:0] filter_gain;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP_LD,
    S_STEP_RUN,
    S_MUL1,
    S_SPD_LD,
    S_SPD_RUN,
    S_MUL2,
    S_ACC_SUM,
    S_ACC_LD,
    S_ACC_RUN,
    S_ACC_FIN,
    S_DONE
  } state_t;

endpackage

### rtl/ese_div.sv
// ----------------------------------------------------------------------------
// ese_div: radix-2 restoring divider
// Shifts one dividend bit into the partial remainder per cycle and one
// quotient bit out, for a requested number of iterations.
// ----------------------------------------------------------------------------
module ese_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ese_pkg::div_ctl_t           ctl,
  input  logic [ese_pkg::DIV_W-1:0]   dividend,
  input  logic [ese_pkg::DEN_W-1:0]   divisor,
  output ese_pkg::div_sts_t           sts,
  output logic [ese_pkg::DIV_W-1:0]   quotient
);
  import ese_pkg::*;

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem_r, quo_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
      cnt_nxt  = ctl.count;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

### rtl/ese_ctl.sv
// ----------------------------------------------------------------------------
// ese_ctl: edge sequencer and estimator state
// Counts position, forms the filter numerators and denominator, runs the
// three divisions in turn on the serial divider and holds the result word.
// ----------------------------------------------------------------------------
module ese_ctl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ese_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ese_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ese_pkg::out_word_t         out_word,
  output ese_pkg::div_ctl_t          div_ctl,
  output logic [ese_pkg::DIV_W-1:0]  div_dividend,
  output logic [ese_pkg::DEN_W-1:0]  div_divisor,
  input  ese_pkg::div_sts_t          div_sts,
  input  logic [ese_pkg::DIV_W-1:0]  div_quotient
);
  import ese_pkg::*;

  state_t state_r, state_nxt;

  logic                    first_edge_r;
  logic [POS_W-1:0]        edge_count_r;
  logic [TS_W-1:0]         last_time_r;
  logic [SPEED_W-1:0]      speed_r;
  logic signed [ACC_W-1:0] accel_r;
  logic                    out_valid_r;
  out_word_t               out_word_r;

  logic [TS_W-1:0]         dt_r;
  logic [DEN_W-1:0]        den_r;
  logic [NUM_W-1:0]        num_r;
  logic [SPEED_W-1:0]      nspeed_r;
  logic signed [DIV_W-1:0] gprod_r;
  logic signed [DIV_W-1:0] anum_r;
  logic                    neg_r;

  logic                    in_acc;
  logic                    out_load;
  logic [GD_W-1:0]         gd_prod;
  logic [GS_W-1:0]         gs_prod;
  logic [NUM_W-1:0]        num_nxt;
  logic [SPEED_W-1:0]      nspeed;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIV_W-1:0] gprod;
  logic signed [DIV_W-1:0] acc_ext;
  logic [DIV_W-1:0]        anum_mag;
  logic [ACC_W-1:0]        acc_sat;
  logic [CPT_W-1:0]        cpt_eff;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign cpt_eff  = (cfg.counts_per_turn == '0) ? CPT_W'(1) : cfg.counts_per_turn;
  assign gd_prod  = cfg.filter_gain * dt_r;
  assign gs_prod  = cfg.filter_gain * div_quotient[STEP_W-1:0];
  assign num_nxt  = NUM_W'(speed_r) + NUM_W'(gs_prod);
  assign nspeed   = (div_quotient[DIV_W-1:SPEED_W] != '0) ? '1
                                                          : div_quotient[SPEED_W-1:0];
  assign diff     = $signed({1'b0, nspeed}) - $signed({1'b0, speed_r});
  assign gprod    = $signed({1'b0, cfg.filter_gain}) * diff;
  assign acc_ext  = {{(DIV_W-ACC_W){accel_r[ACC_W-1]}}, accel_r} <<< FRACTION_BITS;
  assign anum_mag = anum_r[DIV_W-1] ? DIV_W'(-anum_r) : DIV_W'(anum_r);

  always_comb begin
    if (!neg_r) begin
      acc_sat = (div_quotient > DIV_W'(ACC_POS_MAX)) ? ACC_POS_MAX
                                                     : div_quotient[ACC_W-1:0];
    end else begin
      acc_sat = (div_quotient > DIV_W'(ACC_NEG_MAX)) ? ACC_NEG_MAX
                                                     : ACC_W'(-div_quotient[ACC_W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = first_edge_r ? S_DONE : S_STEP_LD;
      end
      S_STEP_LD:  state_nxt = S_STEP_RUN;
      S_STEP_RUN: if (div_sts.done) state_nxt = S_MUL1;
      S_MUL1:     state_nxt = S_SPD_LD;
      S_SPD_LD:   state_nxt = S_SPD_RUN;
      S_SPD_RUN:  if (div_sts.done) state_nxt = S_MUL2;
      S_MUL2:     state_nxt = S_ACC_SUM;
      S_ACC_SUM:  state_nxt = S_ACC_LD;
      S_ACC_LD:   state_nxt = S_ACC_RUN;
      S_ACC_RUN:  if (div_sts.done) state_nxt = S_ACC_FIN;
      S_ACC_FIN:  state_nxt = S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.count = '0;
    div_dividend  = '0;
    div_divisor   = den_r;
    unique case (state_r)
      S_STEP_LD: begin
        div_ctl.start = 1'b1;
        div_ctl.count = STEP_ITER;
        div_dividend  = DIV_W'(FULL_TURN) << (DIV_W - STEP_W);
        div_divisor   = DEN_W'(cpt_eff);
      end
      S_SPD_LD: begin
        div_ctl.start = 1'b1;
        div_ctl.count = SPEED_ITER;
        div_dividend  = DIV_W'(num_r) << (DIV_W - NUM_W);
      end
      S_ACC_LD: begin
        div_ctl.start = 1'b1;
        div_ctl.count = ACC_ITER;
        div_dividend  = anum_mag;
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) dt_r <= in_word.timestamp - last_time_r;
    if (state_r == S_MUL1) begin
      den_r <= (DEN_W'(1) << FRACTION_BITS) + DEN_W'(gd_prod);
      num_r <= num_nxt;
    end
    if (state_r == S_MUL2) begin
      nspeed_r <= nspeed;
      gprod_r  <= gprod;
    end
    if (state_r == S_ACC_SUM) anum_r <= acc_ext + gprod_r;
    if (state_r == S_ACC_LD) neg_r <= anum_r[DIV_W-1];
    if (out_load) begin
      out_word_r.position     <= edge_count_r;
      out_word_r.speed        <= speed_r;
      out_word_r.acceleration <= accel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_edge_r <= 1'b1;
      edge_count_r <= '0;
      last_time_r  <= '0;
      speed_r      <= '0;
      accel_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        first_edge_r <= 1'b0;
        last_time_r  <= in_word.timestamp;
        edge_count_r <= in_word.direction_up ? edge_count_r + 1'b1 : edge_count_r - 1'b1;
      end
      if (state_r == S_ACC_FIN) begin
        accel_r <= acc_sat;
        speed_r <= nspeed_r;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/encoder_speed_estimator.sv
// ----------------------------------------------------------------------------
// encoder_speed_estimator: encoder position counter with low-pass speed and
// acceleration estimates
// Each input word is one encoder edge (timestamp and direction). Each edge
// yields one output word with position, speed and acceleration.
// Input: in_valid / in_stall / in_word; a word is taken when valid is high and
// stall low. Output: out_valid / out_stall / out_word, held while stalled.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// index 0 is counts per turn, index 1 the filter gain, other indexes ignored.
// Write configuration only while no edge is in flight.
// The first edge after reset skips the divisions: it passes through the done
// state straight into the output register. Every later edge runs through one
// bit-serial divider, which performs the angle step (9 iterations), the speed
// (50) and the acceleration (58) divisions in turn, each closed by its done
// flag, plus the multiply, sum, load and finish states around them.
// One edge is worked at a time; in_stall is high from acceptance until the
// result enters the output register, and so also while that register holds an untaken word.
// Reset clears position, time, both estimates and the output valid flag, and
// sets the configuration registers to 20 counts per turn and gain 1311.
// ----------------------------------------------------------------------------
module encoder_speed_estimator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ese_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ese_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ese_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ese_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ese_pkg::*;

  cfg_t             cfg_r;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counts_per_turn <= RESET_COUNTS_PER_TURN;
      cfg_r.filter_gain     <= RESET_FILTER_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUNTS_PER_TURN: cfg_r.counts_per_turn <= cfg_data[CPT_W-1:0];
        CFG_FILTER_GAIN:     cfg_r.filter_gain     <= cfg_data[GAIN_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  ese_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .div_ctl      (div_ctl),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quotient (div_quotient)
  );

  ese_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quotient)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("edge accepted while the sequencer stayed open");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |=> div_sts.busy)
    else $error("divider did not start");

  a_idle_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> in_stall)
    else $error("input open while a division is running");

endmodule
